/* rtl/core/ert_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_pkg
// Types, codes and constants shared by the endpoint record table modules.
// ----------------------------------------------------------------------------
package ert_pkg;

  localparam int unsigned MAX_ENDPOINTS_DEF = 16;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned ADDR_W   = 7;
  localparam int unsigned EP_W     = 8;
  localparam int unsigned MPS_W    = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP     = 3'd0,
    ACT_CONFIGURE  = 3'd1,
    ACT_SET_POLL   = 3'd2,
    ACT_FORGET     = 3'd3,
    ACT_FORGET_ALL = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK             = 2'd0,
    STAT_NOT_CONFIGURED = 2'd1,
    STAT_NO_SPACE       = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_RESOLVE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } seq_state_e;

  // One stored record, 28 bits
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [EP_W-1:0]   ep;
    logic [MPS_W-1:0]  mps;
    logic              snd;
    logic              rcv;
    logic              poll;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   dev_addr;
    logic [EP_W-1:0]     endpoint;
    logic [MPS_W-1:0]    max_packet;
    logic                send_toggle;
    logic                recv_toggle;
    logic                poll_flag;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [MPS_W-1:0]    packet_size;
    logic                out_toggle;
    logic                in_toggle;
    logic                auto_poll;
    logic [COUNT_W-1:0]  entry_count;
  } res_t;

endpackage

/* rtl/core/endpoint_record_table.sv */
`timescale 1ns / 1ps
// Operations: lookup, configure and set auto-poll on a record at slot k read and
//   compare slots 0 to k in turn; a miss scans all stored records.
// Forget then shifts each later record down one slot; forget-all does no scan.
// Throughput: one transaction at a time; a new one is taken once the result is out.
// Reset: table empties (count cleared); record RAM contents are left as is.
// ----------------------------------------------------------------------------
// endpoint_record_table
// Packed table of USB endpoint records with lookup, configure, set
// auto-poll, forget and forget-all operations.
// ----------------------------------------------------------------------------
module endpoint_record_table #(
  parameter int unsigned MAX_ENDPOINTS = ert_pkg::MAX_ENDPOINTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ert_pkg::ACTION_W-1:0]  action_i,
  input  logic [ert_pkg::ADDR_W-1:0]    dev_addr_i,
  input  logic [ert_pkg::EP_W-1:0]      endpoint_i,
  input  logic [ert_pkg::MPS_W-1:0]     max_packet_i,
  input  logic                          send_toggle_i,
  input  logic                          recv_toggle_i,
  input  logic                          poll_flag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ert_pkg::STATUS_W-1:0]  status_o,
  output logic                          found_o,
  output logic [ert_pkg::SLOT_W-1:0]    slot_o,
  output logic [ert_pkg::MPS_W-1:0]     packet_size_o,
  output logic                          out_toggle_o,
  output logic                          in_toggle_o,
  output logic                          auto_poll_o,
  output logic [ert_pkg::COUNT_W-1:0]   entry_count_o
);
  import ert_pkg::*;

  localparam int unsigned IDX_W = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;

  req_t             req;
  res_t             res;
  logic             res_valid;
  logic             res_ready;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rec_t             ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  rec_t             ram_rdata;

  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  always_comb begin
    req.action      = action_i;
    req.dev_addr    = dev_addr_i;
    req.endpoint    = endpoint_i;
    req.max_packet  = max_packet_i;
    req.send_toggle = send_toggle_i;
    req.recv_toggle = recv_toggle_i;
    req.poll_flag   = poll_flag_i;
  end

  ert_seq #(
    .MAX_ENDPOINTS(MAX_ENDPOINTS),
    .IDX_W        (IDX_W)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_ready_o(in_ready_o),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  ert_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_ENDPOINTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // output register decouples the consumer from the sequencer
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign found_o       = out_q.found;
  assign slot_o        = out_q.slot;
  assign packet_size_o = out_q.packet_size;
  assign out_toggle_o  = out_q.out_toggle;
  assign in_toggle_o   = out_q.in_toggle;
  assign auto_poll_o   = out_q.auto_poll;
  assign entry_count_o = out_q.entry_count;

endmodule

/* rtl/core/ert_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ert_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ert_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_seq
// Sequencer: scans the record RAM for a key, then reports, updates, appends or
// deletes with a shift-down pass; forget-all clears the table without a scan.
// ----------------------------------------------------------------------------
module ert_seq #(
  parameter int unsigned MAX_ENDPOINTS = ert_pkg::MAX_ENDPOINTS_DEF,
  parameter int unsigned IDX_W = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  ert_pkg::req_t     req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output ert_pkg::res_t     res_o,
  output logic              ram_we_o,
  output logic [IDX_W-1:0]  ram_waddr_o,
  output ert_pkg::rec_t     ram_wdata_o,
  output logic              ram_re_o,
  output logic [IDX_W-1:0]  ram_raddr_o,
  input  ert_pkg::rec_t     ram_rdata_i
);
  import ert_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ENDPOINTS + 1);

  seq_state_e       state_q, state_d;
  req_t             req_q, req_d;
  res_t             res_q, res_d;
  rec_t             rec_q, rec_d;
  logic             hit_q, hit_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;

  logic [CNT_W:0]   scan_nxt;
  logic             more;
  logic             key_match;
  logic             accept;
  action_e          act;
  rec_t             new_rec;

  assign scan_nxt  = {1'b0, scan_q} + 1'b1;
  assign more      = scan_nxt < {1'b0, count_q};
  assign key_match = (ram_rdata_i.addr == req_q.dev_addr) &&
                     (ram_rdata_i.ep == req_q.endpoint);
  assign accept    = req_valid_i && req_ready_o;
  assign act       = action_e'(req_q.action);

  always_comb begin
    new_rec.addr = req_q.dev_addr;
    new_rec.ep   = req_q.endpoint;
    new_rec.mps  = req_q.max_packet;
    new_rec.snd  = req_q.send_toggle;
    new_rec.rcv  = req_q.recv_toggle;
    new_rec.poll = req_q.poll_flag;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((req_i.action == ACT_FORGET_ALL) || (req_i.action > ACT_FORGET_ALL) ||
              (count_q == '0)) begin
            state_d = S_RESOLVE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: state_d = S_CMP;
      S_CMP: begin
        if (key_match || !more) begin
          state_d = S_RESOLVE;
        end else begin
          state_d = S_READ;
        end
      end
      S_RESOLVE: begin
        if ((act == ACT_FORGET) && hit_q) begin
          state_d = S_SHIFT_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT_RD: state_d = more ? S_SHIFT_WR : S_DONE;
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs, RAM control and datapath
  always_comb begin
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = scan_q[IDX_W-1:0];
    ram_wdata_o = new_rec;
    ram_re_o    = 1'b0;
    ram_raddr_o = scan_q[IDX_W-1:0];
    req_d       = req_q;
    res_d       = res_q;
    rec_d       = rec_q;
    hit_d       = hit_q;
    count_d     = count_q;
    scan_d      = scan_q;

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (accept) begin
          req_d  = req_i;
          hit_d  = 1'b0;
          scan_d = '0;
        end
      end
      S_READ: begin
        ram_re_o = 1'b1;
      end
      S_CMP: begin
        if (key_match) begin
          hit_d = 1'b1;
          rec_d = ram_rdata_i;
        end else if (more) begin
          scan_d = scan_nxt[CNT_W-1:0];
        end
      end
      S_RESOLVE: begin
        res_d = '0;
        unique case (act)
          ACT_LOOKUP: begin
            if (hit_q) begin
              res_d.found       = 1'b1;
              res_d.slot        = SLOT_W'(scan_q);
              res_d.packet_size = rec_q.mps;
              res_d.out_toggle  = rec_q.snd;
              res_d.in_toggle   = rec_q.rcv;
              res_d.auto_poll   = rec_q.poll;
            end else begin
              res_d.status = STAT_NOT_CONFIGURED;
            end
          end
          ACT_CONFIGURE: begin
            if (hit_q || (count_q < CNT_W'(MAX_ENDPOINTS))) begin
              ram_we_o          = 1'b1;
              res_d.found       = hit_q;
              res_d.slot        = hit_q ? SLOT_W'(scan_q) : SLOT_W'(count_q);
              res_d.packet_size = new_rec.mps;
              res_d.out_toggle  = new_rec.snd;
              res_d.in_toggle   = new_rec.rcv;
              res_d.auto_poll   = new_rec.poll;
              if (!hit_q) begin
                // append at the end of the packed table
                ram_waddr_o = count_q[IDX_W-1:0];
                count_d     = count_q + 1'b1;
              end
            end else begin
              res_d.status = STAT_NO_SPACE;
            end
          end
          ACT_SET_POLL: begin
            if (hit_q) begin
              ram_we_o          = 1'b1;
              ram_wdata_o       = rec_q;
              ram_wdata_o.poll  = req_q.poll_flag;
              res_d.found       = 1'b1;
              res_d.slot        = SLOT_W'(scan_q);
              res_d.packet_size = rec_q.mps;
              res_d.out_toggle  = rec_q.snd;
              res_d.in_toggle   = rec_q.rcv;
              res_d.auto_poll   = req_q.poll_flag;
            end else begin
              res_d.status = STAT_NOT_CONFIGURED;
            end
          end
          ACT_FORGET: begin
            if (hit_q) begin
              res_d.found       = 1'b1;
              res_d.slot        = SLOT_W'(scan_q);
              res_d.packet_size = rec_q.mps;
              res_d.out_toggle  = rec_q.snd;
              res_d.in_toggle   = rec_q.rcv;
              res_d.auto_poll   = rec_q.poll;
            end else begin
              res_d.status = STAT_NOT_CONFIGURED;
            end
          end
          ACT_FORGET_ALL: begin
            count_d = '0;
          end
          default: ;
        endcase
      end
      S_SHIFT_RD: begin
        if (more) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = scan_nxt[IDX_W-1:0];
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      S_SHIFT_WR: begin
        // move record j+1 down into slot j
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i;
        scan_d      = scan_nxt[CNT_W-1:0];
      end
      S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o             = res_q;
    res_o.entry_count = COUNT_W'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    rec_q  <= rec_d;
    hit_q  <= hit_d;
    scan_q <= scan_d;
  end

endmodule

/* rtl/core/ert_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_checker
// Port-level checks for the endpoint record table, bound to the top level.
// ----------------------------------------------------------------------------
module ert_checker #(
  parameter int unsigned MAX_ENDPOINTS = ert_pkg::MAX_ENDPOINTS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [ert_pkg::ACTION_W-1:0]  action_i,
  input logic [ert_pkg::ADDR_W-1:0]    dev_addr_i,
  input logic [ert_pkg::EP_W-1:0]      endpoint_i,
  input logic [ert_pkg::MPS_W-1:0]     max_packet_i,
  input logic                          send_toggle_i,
  input logic                          recv_toggle_i,
  input logic                          poll_flag_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ert_pkg::STATUS_W-1:0]  status_o,
  input logic                          found_o,
  input logic [ert_pkg::SLOT_W-1:0]    slot_o,
  input logic [ert_pkg::MPS_W-1:0]     packet_size_o,
  input logic                          out_toggle_o,
  input logic                          in_toggle_o,
  input logic                          auto_poll_o,
  input logic [ert_pkg::COUNT_W-1:0]   entry_count_o
);
  import ert_pkg::*;

  // one transaction in flight: no back-to-back acceptance
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o) &&
      $stable(slot_o) && $stable(entry_count_o)))
    else $error("result dropped or changed while stalled");

  // a failed operation reports no record
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> (!found_o && (slot_o == '0) &&
      (packet_size_o == '0) && !out_toggle_o && !in_toggle_o && !auto_poll_o))
    else $error("failed result carries record data");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_NO_SPACE)) |->
      (entry_count_o == COUNT_W'(MAX_ENDPOINTS)))
    else $error("out of space reported with table not full");

endmodule

bind endpoint_record_table ert_checker #(.MAX_ENDPOINTS(MAX_ENDPOINTS)) u_ert_checker (.*);

/* tb/sv/endpoint_record_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// endpoint_record_table_tb
// Self-checking bench for the endpoint record table. A queued driver feeds
// directed and random operations through the request handshake. Each
// accepted operation is applied to a local table model, and the monitor
// checks every response field against the oldest predicted response.
// ----------------------------------------------------------------------------
module endpoint_record_table_tb;
  import ert_pkg::*;

  localparam int unsigned TABLE_DEPTH  = MAX_ENDPOINTS_DEF;
  localparam int          NO_MATCH     = -1;
  localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_LAST_UNUSED  = 3'd7;
  localparam int unsigned TARGET_ITEMS = 550;
  localparam int unsigned KEY_POOL     = 24;
  localparam int unsigned HOLD_AFTER   = 150;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [ACTION_W-1:0] action_i      = '0;
  logic [ADDR_W-1:0]   dev_addr_i    = '0;
  logic [EP_W-1:0]     endpoint_i    = '0;
  logic [MPS_W-1:0]    max_packet_i  = '0;
  logic                send_toggle_i = 1'b0;
  logic                recv_toggle_i = 1'b0;
  logic                poll_flag_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic                found_o;
  logic [SLOT_W-1:0]   slot_o;
  logic [MPS_W-1:0]    packet_size_o;
  logic                out_toggle_o;
  logic                in_toggle_o;
  logic                auto_poll_o;
  logic [COUNT_W-1:0]  entry_count_o;

  req_t pending_items[$];
  res_t expected_results[$];
  int   items_queued = 0;
  int   items_sent   = 0;
  int   results_seen = 0;
  int   fault_count  = 0;
  int   send_gap     = 0;
  int   recv_wait    = 0;

  // local copy of the endpoint table
  rec_t record_table[TABLE_DEPTH];
  int   table_count = 0;

  always #5 clk_i = ~clk_i;

  endpoint_record_table #(
    .MAX_ENDPOINTS(TABLE_DEPTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .dev_addr_i    (dev_addr_i),
    .endpoint_i    (endpoint_i),
    .max_packet_i  (max_packet_i),
    .send_toggle_i (send_toggle_i),
    .recv_toggle_i (recv_toggle_i),
    .poll_flag_i   (poll_flag_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .slot_o        (slot_o),
    .packet_size_o (packet_size_o),
    .out_toggle_o  (out_toggle_o),
    .in_toggle_o   (in_toggle_o),
    .auto_poll_o   (auto_poll_o),
    .entry_count_o (entry_count_o)
  );

  function automatic res_t show_record(res_t res, int idx, rec_t rec);
    res.slot        = SLOT_W'(idx);
    res.packet_size = rec.mps;
    res.out_toggle  = rec.snd;
    res.in_toggle   = rec.rcv;
    res.auto_poll   = rec.poll;
    return res;
  endfunction

  // Applies one operation to the local table and returns the response.
  function automatic res_t apply_request(req_t req);
    res_t res;
    rec_t gone;
    int   hit;
    res = '0;
    hit = NO_MATCH;
    // scan downward so the lowest matching slot wins
    for (int i = table_count - 1; i >= 0; i--) begin
      if (record_table[i].addr == req.dev_addr && record_table[i].ep == req.endpoint) begin
        hit = i;
      end
    end
    case (req.action)
      ACT_LOOKUP: begin
        if (hit != NO_MATCH) begin
          res.found = 1'b1;
          res       = show_record(res, hit, record_table[hit]);
        end else begin
          res.status = STAT_NOT_CONFIGURED;
        end
      end
      ACT_CONFIGURE: begin
        if (hit != NO_MATCH) begin
          record_table[hit].mps  = req.max_packet;
          record_table[hit].snd  = req.send_toggle;
          record_table[hit].rcv  = req.recv_toggle;
          record_table[hit].poll = req.poll_flag;
          res.found = 1'b1;
          res       = show_record(res, hit, record_table[hit]);
        end else if (table_count < TABLE_DEPTH) begin
          record_table[table_count] = {req.dev_addr, req.endpoint, req.max_packet,
                                       req.send_toggle, req.recv_toggle, req.poll_flag};
          res = show_record(res, table_count, record_table[table_count]);
          table_count++;
        end else begin
          res.status = STAT_NO_SPACE;
        end
      end
      ACT_SET_POLL: begin
        if (hit != NO_MATCH) begin
          record_table[hit].poll = req.poll_flag;
          res.found = 1'b1;
          res       = show_record(res, hit, record_table[hit]);
        end else begin
          res.status = STAT_NOT_CONFIGURED;
        end
      end
      ACT_FORGET: begin
        if (hit != NO_MATCH) begin
          gone = record_table[hit];
          for (int j = hit; j < table_count - 1; j++) begin
            record_table[j] = record_table[j + 1];
          end
          table_count--;
          res.found = 1'b1;
          res       = show_record(res, hit, gone);
        end else begin
          res.status = STAT_NOT_CONFIGURED;
        end
      end
      ACT_FORGET_ALL: begin
        table_count = 0;
      end
      default: ;
    endcase
    res.entry_count = COUNT_W'(table_count);
    return res;
  endfunction

  task automatic add_item(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
                          input logic [EP_W-1:0] ep, input logic [MPS_W-1:0] mps,
                          input logic [2:0] flags);
    pending_items.push_back({act, addr, ep, mps, flags});
    items_queued++;
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got = {status_o, found_o, slot_o, packet_size_o, out_toggle_o, in_toggle_o,
           auto_poll_o, entry_count_o};
    if (expected_results.size() == 0) begin
      $error("response with no transaction outstanding: status %0d", got.status);
      fault_count++;
      return;
    end
    want = expected_results.pop_front();
    if (got.status != want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fault_count++;
    end
    if (got.found != want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      fault_count++;
    end
    if (got.slot != want.slot) begin
      $error("slot: expected %0d, got %0d", want.slot, got.slot);
      fault_count++;
    end
    if (got.packet_size != want.packet_size) begin
      $error("packet_size: expected %0d, got %0d", want.packet_size, got.packet_size);
      fault_count++;
    end
    if (got.out_toggle != want.out_toggle) begin
      $error("out_toggle: expected %0d, got %0d", want.out_toggle, got.out_toggle);
      fault_count++;
    end
    if (got.in_toggle != want.in_toggle) begin
      $error("in_toggle: expected %0d, got %0d", want.in_toggle, got.in_toggle);
      fault_count++;
    end
    if (got.auto_poll != want.auto_poll) begin
      $error("auto_poll: expected %0d, got %0d", want.auto_poll, got.auto_poll);
      fault_count++;
    end
    if (got.entry_count != want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      fault_count++;
    end
  endtask

  // Request driver: predicts on acceptance, then offers the next queued item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      send_gap    <= 0;
      table_count = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(apply_request({action_i, dev_addr_i, endpoint_i,
                                                  max_packet_i, send_toggle_i,
                                                  recv_toggle_i, poll_flag_i}));
        items_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          {action_i, dev_addr_i, endpoint_i, max_packet_i, send_toggle_i, recv_toggle_i,
           poll_flag_i} <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          // every third stretch of 60 transactions goes back to back
          send_gap   <= ((items_sent / 60) % 3 == 2) ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random backpressure and one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait   = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_result();
        results_seen++;
        if (results_seen == HOLD_AFTER) begin
          recv_wait = HOLD_CYCLES;
        end else if ((results_seen / 64) % 3 == 1) begin
          recv_wait = 0;
        end else begin
          recv_wait = $urandom_range(0, 7);
        end
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_ready_i <= (recv_wait == 0);
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0]   pool_addr[KEY_POOL];
    logic [EP_W-1:0]     pool_ep[KEY_POOL];
    logic [ADDR_W-1:0]   fill_addr;
    logic [EP_W-1:0]     fill_ep[TABLE_DEPTH];
    logic [ACTION_W-1:0] act;
    int                  roll;
    int                  pick;
    int                  run_len;

    for (int i = 0; i < KEY_POOL; i++) begin
      pool_addr[i] = ADDR_W'($urandom);
      pool_ep[i]   = EP_W'($urandom);
    end
    pool_addr[0] = '0;
    pool_ep[0]   = '0;
    pool_addr[1] = '1;
    pool_ep[1]   = '1;

    // directed: empty table, unused codes, key extremes, shift on forget
    add_item(ACT_FORGET_ALL, '1, '1, '1, 3'b111);
    add_item(ACT_LOOKUP, '0, '0, '0, 3'b000);
    add_item(ACT_FIRST_UNUSED, '1, '1, '1, 3'b111);
    add_item(ACT_FIRST_UNUSED + 3'd1, 7'h55, 8'haa, 10'h155, 3'b101);
    add_item(ACT_LAST_UNUSED, '0, '0, '0, 3'b000);
    add_item(ACT_SET_POLL, '1, '1, '0, 3'b111);
    add_item(ACT_FORGET, '1, '1, '0, 3'b000);
    add_item(ACT_CONFIGURE, '0, '0, '0, 3'b000);
    add_item(ACT_CONFIGURE, '1, '1, '1, 3'b111);
    add_item(ACT_LOOKUP, '0, '0, '0, 3'b000);
    add_item(ACT_LOOKUP, '1, '1, '0, 3'b000);
    add_item(ACT_CONFIGURE, '0, '0, '1, 3'b101);
    add_item(ACT_SET_POLL, '1, '1, '0, 3'b000);
    add_item(ACT_LOOKUP, '1, '1, '0, 3'b000);
    add_item(ACT_FORGET, '0, '0, '0, 3'b000);
    add_item(ACT_LOOKUP, '1, '1, '0, 3'b000);
    add_item(ACT_CONFIGURE, '0, '0, 10'd512, 3'b010);
    add_item(ACT_FORGET, '0, '0, '0, 3'b000);
    add_item(ACT_FORGET_ALL, '0, '0, '0, 3'b000);
    add_item(ACT_LOOKUP, '1, '1, '0, 3'b000);

    for (int k = 0; items_queued < TARGET_ITEMS; k++) begin
      roll = $urandom_range(0, 99);
      if (k == 0 || roll < 12) begin
        // fill the table to the brim, overflow it, then work on the full table
        fill_addr = ADDR_W'($urandom);
        add_item(ACT_FORGET_ALL, ADDR_W'($urandom), EP_W'($urandom), MPS_W'($urandom),
                 3'($urandom));
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          fill_ep[i] = {4'($urandom), 4'(i)};
          add_item(ACT_CONFIGURE, fill_addr, fill_ep[i], MPS_W'($urandom), 3'($urandom));
        end
        run_len = $urandom_range(1, 2);
        for (int i = 0; i < run_len; i++) begin
          add_item(ACT_CONFIGURE, fill_addr ^ 7'd1, EP_W'($urandom), MPS_W'($urandom),
                   3'($urandom));
        end
        run_len = $urandom_range(3, 8);
        for (int i = 0; i < run_len; i++) begin
          pick = $urandom_range(0, TABLE_DEPTH - 1);
          act  = ACTION_W'($urandom_range(ACT_LOOKUP, ACT_FORGET));
          add_item(act, fill_addr, fill_ep[pick], MPS_W'($urandom), 3'($urandom));
        end
      end else if (roll < 20) begin
        run_len = $urandom_range(1, 4);
        for (int i = 0; i < run_len; i++) begin
          add_item(ACTION_W'($urandom), ADDR_W'($urandom), EP_W'($urandom),
                   MPS_W'($urandom), 3'($urandom));
        end
      end else begin
        run_len = $urandom_range(4, 10);
        for (int i = 0; i < run_len; i++) begin
          pick = $urandom_range(0, KEY_POOL - 1);
          roll = $urandom_range(0, 99);
          if (roll < 30) begin
            act = ACT_CONFIGURE;
          end else if (roll < 55) begin
            act = ACT_LOOKUP;
          end else if (roll < 70) begin
            act = ACT_SET_POLL;
          end else if (roll < 90) begin
            act = ACT_FORGET;
          end else if (roll < 93) begin
            act = ACT_FORGET_ALL;
          end else begin
            act = ACTION_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
          end
          add_item(act, pool_addr[pick], pool_ep[pick], MPS_W'($urandom), 3'($urandom));
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ert_pkg.sv
rtl/core/ert_ram.sv
rtl/core/ert_seq.sv
rtl/core/endpoint_record_table.sv
rtl/core/ert_checker.sv
tb/sv/endpoint_record_table_tb.sv
